FILE: rtl/core/apr_pkg.sv
package apr_pkg;

  localparam int OFFSET_BITS   = 10;
  localparam int COEF_BITS     = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int NUM_STAGES    = 4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_ONE   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_TWO   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_THREE = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_FOUR  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DAMP_COEF    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WET_GAIN     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DRY_GAIN     = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FEEDBACK     = 3'd7;

  localparam logic [OFFSET_BITS-1:0] RST_OFFSET_ONE   = 10'd202;
  localparam logic [OFFSET_BITS-1:0] RST_OFFSET_TWO   = 10'd268;
  localparam logic [OFFSET_BITS-1:0] RST_OFFSET_THREE = 10'd523;
  localparam logic [OFFSET_BITS-1:0] RST_OFFSET_FOUR  = 10'd716;
  localparam logic [COEF_BITS-1:0]   RST_DAMP_COEF    = 16'd44564;
  localparam logic [COEF_BITS-1:0]   RST_WET_GAIN     = 16'd11796;
  localparam logic [COEF_BITS-1:0]   RST_DRY_GAIN     = 16'd3113;
  localparam logic [COEF_BITS-1:0]   RST_FEEDBACK     = 16'd26214;

  localparam logic [1:0] STAGE_LEFT_TAP = 2'd2;
  localparam logic [1:0] STAGE_LAST     = 2'd3;

  localparam logic [4:0] SHIFT_GAIN = 5'd14;
  localparam logic [4:0] SHIFT_FB   = 5'd15;
  localparam logic [4:0] SHIFT_DAMP = 5'd16;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WET,
    ST_DIFF,
    ST_DAMP,
    ST_UPD,
    ST_DRYA,
    ST_DLA,
    ST_DRYB,
    ST_DLB,
    ST_FB,
    ST_SUB,
    ST_ADD,
    ST_OUTL,
    ST_DONE
  } apr_state_t;

  typedef enum logic [2:0] {
    MUL_WET,
    MUL_DAMP,
    MUL_DRYA,
    MUL_DRYB,
    MUL_FB
  } mul_sel_t;

  typedef struct packed {
    logic       clear;
    logic       start;
    logic       mul_en;
    mul_sel_t   mul_sel;
    logic       diff_en;
    logic       upd_en;
    logic       dla_en;
    logic       dlb_en;
    logic       ap_sub;
    logic       ap_add;
    logic [1:0] stage;
    logic       outl_en;
    logic       finish;
  } apr_cmd_t;

  typedef struct packed {
    logic ptr_last;
    logic out_busy;
  } apr_status_t;

endpackage

FILE: rtl/core/apr_line.sv
module apr_line
  import apr_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/apr_ctrl.sv
module apr_ctrl
  import apr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  apr_status_t status,
  output apr_cmd_t    cmd
);

  apr_state_t state, state_next;
  logic [1:0] stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      stage <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DLB) begin
        stage <= '0;
      end else if (state == ST_ADD) begin
        stage <= stage + 2'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (status.ptr_last) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_WET;
      ST_WET:   state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_DAMP;
      ST_DAMP:  state_next = ST_UPD;
      ST_UPD:   state_next = ST_DRYA;
      ST_DRYA:  state_next = ST_DLA;
      ST_DLA:   state_next = ST_DRYB;
      ST_DRYB:  state_next = ST_DLB;
      ST_DLB:   state_next = ST_FB;
      ST_FB:    state_next = ST_SUB;
      ST_SUB:   state_next = ST_ADD;
      ST_ADD: begin
        priority if (stage == STAGE_LEFT_TAP) state_next = ST_OUTL;
        else if (stage == STAGE_LAST)         state_next = ST_DONE;
        else                                  state_next = ST_FB;
      end
      ST_OUTL:  state_next = ST_FB;
      ST_DONE:  if (!status.out_busy) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.stage = stage;
    in_ready  = 1'b0;
    unique case (state)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_WET: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_WET;
      end
      ST_DIFF: cmd.diff_en = 1'b1;
      ST_DAMP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DAMP;
      end
      ST_UPD: cmd.upd_en = 1'b1;
      ST_DRYA: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DRYA;
      end
      ST_DLA: cmd.dla_en = 1'b1;
      ST_DRYB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DRYB;
      end
      ST_DLB: cmd.dlb_en = 1'b1;
      ST_FB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FB;
      end
      ST_SUB:  cmd.ap_sub  = 1'b1;
      ST_ADD:  cmd.ap_add  = 1'b1;
      ST_OUTL: cmd.outl_en = 1'b1;
      ST_DONE: cmd.finish  = !status.out_busy;
      default: cmd.clear   = 1'b0;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_WET))
    else $error("accepted word did not start the sequence");

  a_left_tap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD && stage == STAGE_LEFT_TAP) |=> (state == ST_OUTL))
    else $error("left output not taken after the third stage");

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && status.ptr_last) |=> (state == ST_IDLE))
    else $error("clearing pass did not end");

endmodule

FILE: rtl/core/apr_datapath.sv
module apr_datapath
  import apr_pkg::*;
#(
  parameter int LINE_DEPTH  = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] in_left,
  input  logic signed [SAMPLE_BITS-1:0] in_right,
  input  apr_cmd_t                      cmd,
  output apr_status_t                   status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right
);

  localparam int LW   = $clog2(LINE_DEPTH);
  localparam int XW   = SAMPLE_BITS + 3;
  localparam int AW   = ((XW > 32) ? XW : 32) + 1;
  localparam int WW   = AW + 2;
  localparam int BW   = COEF_BITS + 1;
  localparam int PW   = AW + BW;
  localparam int SUMW = ((LW > OFFSET_BITS) ? LW : OFFSET_BITS) + 1;
  localparam int NRED = ((2 ** OFFSET_BITS) + LINE_DEPTH - 1) / LINE_DEPTH;

  function automatic logic signed [31:0] sat32(input logic signed [WW-1:0] v);
    logic [WW-32:0] hi;
    hi = v[WW-1:31];
    if ((&hi) || !(|hi)) begin
      return v[31:0];
    end
    return v[WW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_s(input logic signed [WW-1:0] v);
    logic [WW-SAMPLE_BITS:0] hi;
    hi = v[WW-1:SAMPLE_BITS-1];
    if ((&hi) || !(|hi)) begin
      return v[SAMPLE_BITS-1:0];
    end
    return v[WW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  endfunction

  logic [OFFSET_BITS-1:0] offs [NUM_STAGES];
  logic [COEF_BITS-1:0]   damp_coef, wet_gain, dry_gain, feedback;

  logic signed [SAMPLE_BITS-1:0] a, b, left_hold;
  logic signed [SAMPLE_BITS-1:0] tap [NUM_STAGES];
  logic signed [SAMPLE_BITS-1:0] t_sel, wdata;
  logic signed [WW-1:0]          p, dl_a, dl_b, r_sub, r_add, f_ext, r_ext;
  logic signed [AW-1:0]          diff, mul_a;
  logic signed [BW-1:0]          mul_b;
  logic signed [PW-1:0]          prod, prod_sh;
  logic [4:0]                    shift;
  logic signed [31:0]            f, r, r_sub_sat;
  logic [LW-1:0]                 ptr, ptr_next, waddr;
  logic [SUMW-1:0]               wsum;
  logic                          ptr_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      offs[0]   <= RST_OFFSET_ONE;
      offs[1]   <= RST_OFFSET_TWO;
      offs[2]   <= RST_OFFSET_THREE;
      offs[3]   <= RST_OFFSET_FOUR;
      damp_coef <= RST_DAMP_COEF;
      wet_gain  <= RST_WET_GAIN;
      dry_gain  <= RST_DRY_GAIN;
      feedback  <= RST_FEEDBACK;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET_ONE:   offs[0]   <= cfg_data[OFFSET_BITS-1:0];
        CFG_OFFSET_TWO:   offs[1]   <= cfg_data[OFFSET_BITS-1:0];
        CFG_OFFSET_THREE: offs[2]   <= cfg_data[OFFSET_BITS-1:0];
        CFG_OFFSET_FOUR:  offs[3]   <= cfg_data[OFFSET_BITS-1:0];
        CFG_DAMP_COEF:    damp_coef <= cfg_data;
        CFG_WET_GAIN:     wet_gain  <= cfg_data;
        CFG_DRY_GAIN:     dry_gain  <= cfg_data;
        CFG_FEEDBACK:     feedback  <= cfg_data;
      endcase
    end
  end

  assign ptr_last = (ptr == LW'(LINE_DEPTH - 1));
  assign ptr_next = ptr_last ? '0 : ptr + LW'(1);
  assign t_sel    = tap[cmd.stage];
  assign f_ext    = WW'(f);
  assign r_ext    = WW'(r);

  always_comb begin
    wsum = SUMW'(ptr) + SUMW'(offs[cmd.stage]);
    for (int i = 0; i < NRED; i++) begin
      if (wsum >= SUMW'(LINE_DEPTH)) begin
        wsum = wsum - SUMW'(LINE_DEPTH);
      end
    end
    waddr = wsum[LW-1:0];
  end

  assign r_sub     = r_ext - p;
  assign r_sub_sat = sat32(r_sub);
  assign r_add     = r_ext + WW'(t_sel);
  assign wdata     = cmd.clear ? '0 : sat_s(WW'(r_sub_sat));

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_line
    apr_line #(
      .DEPTH(LINE_DEPTH),
      .WIDTH(SAMPLE_BITS)
    ) u_line (
      .clk  (clk),
      .we   (cmd.clear || (cmd.ap_sub && cmd.stage == 2'(k))),
      .waddr(cmd.clear ? ptr : waddr),
      .wdata(wdata),
      .re   (cmd.start),
      .raddr(ptr),
      .rdata(tap[k])
    );
  end

  always_comb begin
    mul_a = AW'(t_sel);
    mul_b = BW'(feedback);
    shift = SHIFT_FB;
    unique case (cmd.mul_sel)
      MUL_WET: begin
        mul_a = AW'(a) + AW'(b);
        mul_b = BW'(wet_gain);
        shift = SHIFT_GAIN;
      end
      MUL_DAMP: begin
        mul_a = diff;
        mul_b = BW'(damp_coef);
        shift = SHIFT_DAMP;
      end
      MUL_DRYA: begin
        mul_a = AW'(a);
        mul_b = BW'(dry_gain);
        shift = SHIFT_GAIN;
      end
      MUL_DRYB: begin
        mul_a = AW'(b);
        mul_b = BW'(dry_gain);
        shift = SHIFT_GAIN;
      end
      MUL_FB: begin
        mul_a = AW'(t_sel);
        mul_b = BW'(feedback);
        shift = SHIFT_FB;
      end
      default: shift = SHIFT_FB;
    endcase
    prod    = PW'(mul_a) * PW'(mul_b);
    prod_sh = prod >>> shift;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a <= in_left;
      b <= in_right;
    end
    if (cmd.mul_en) p <= WW'(prod_sh);
    if (cmd.diff_en) diff <= AW'(p - f_ext);
    if (cmd.dla_en) dl_a <= p - f_ext;
    if (cmd.dlb_en) dl_b <= p - f_ext;
    if (cmd.outl_en) left_hold <= sat_s(dl_a + r_ext);
    if (cmd.finish) begin
      out_left  <= left_hold;
      out_right <= sat_s(dl_b + r_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f         <= '0;
      r         <= '0;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.upd_en) begin
        f <= sat32(p + f_ext);
        r <= sat32(p + f_ext);
      end else if (cmd.ap_sub) begin
        r <= r_sub_sat;
      end else if (cmd.ap_add) begin
        r <= sat32(r_add);
      end
      if (cmd.clear || cmd.finish) ptr <= ptr_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.ptr_last = ptr_last;
  assign status.out_busy = out_valid && !out_ready;

endmodule

FILE: rtl/core/allpass_ambience_reverb_core.sv
// Stereo ambience reverb: each input word carries one left and one right sample, and each
// output word carries the left and right reverb outputs. One shared multiplier and one
// sequencer process each sample pair in turn, and no new pair is accepted until the last
// one is done; the output register holds a finished word so the next pair can be taken
// while it waits. After reset the four delay lines are swept to zero, one entry per cycle,
// and no input is accepted until that pass is over. Configuration registers may be
// written at any time the block is idle.
module allpass_ambience_reverb_core
  import apr_pkg::*;
#(
  parameter int LINE_DEPTH  = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]                  cfg_index,
  input  logic [CFG_DATA_BITS-1:0]                 cfg_data,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // Fields from bit 0: left_in, right_in, zero padding.
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // Fields from bit 0: left_out, right_out, zero padding.
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata
);

  localparam int TW = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  apr_cmd_t    cmd;
  apr_status_t status;
  logic signed [SAMPLE_BITS-1:0] in_left, in_right, out_left, out_right;

  assign in_left  = s_axis_tdata[SAMPLE_BITS-1:0];
  assign in_right = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

  apr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .status  (status),
    .cmd     (cmd)
  );

  apr_datapath #(
    .LINE_DEPTH (LINE_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_left  (in_left),
    .in_right (in_right),
    .cmd      (cmd),
    .status   (status),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_left (out_left),
    .out_right(out_right)
  );

  assign m_axis_tdata = TW'({out_right, out_left});

endmodule

FILE: test/allpass_ambience_reverb_core_tb.sv
module allpass_ambience_reverb_core_tb;
  import apr_pkg::*;

  localparam int LINE_DEPTH  = 1024;
  localparam int SAMPLE_BITS = 24;
  localparam int DATA_BITS   = ((2*SAMPLE_BITS+7)/8)*8;
  localparam longint SMAX    = (64'sd1 <<< (SAMPLE_BITS-1)) - 1;
  localparam longint SMIN    = -SMAX - 1;
  localparam int RANDOM_WORDS = 1250;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] right;
    logic signed [SAMPLE_BITS-1:0] left;
  } pair_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [DATA_BITS-1:0]     s_axis_tdata = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [DATA_BITS-1:0]     m_axis_tdata;

  allpass_ambience_reverb_core #(
    .LINE_DEPTH(LINE_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk = ~clk;

  logic [OFFSET_BITS-1:0] ofs [NUM_STAGES];
  logic [COEF_BITS-1:0]   damp_coef, wet_gain, dry_gain, feedback;
  longint                 damped;
  int                     pointer;
  longint                 lines [NUM_STAGES][LINE_DEPTH];

  pair_t  expected_out [$];
  int     errors = 0;
  bit     stall_rx = 1'b1;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint clip32(longint v);
    return clip(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  task automatic reset_model();
    ofs[0] = RST_OFFSET_ONE; ofs[1] = RST_OFFSET_TWO;
    ofs[2] = RST_OFFSET_THREE; ofs[3] = RST_OFFSET_FOUR;
    damp_coef = RST_DAMP_COEF; wet_gain = RST_WET_GAIN;
    dry_gain = RST_DRY_GAIN; feedback = RST_FEEDBACK;
    damped = 0; pointer = 0;
    foreach (lines[s, i]) lines[s][i] = 0;
  endtask

  function automatic pair_t reverb_pair(pair_t din);
    longint a, b, x, r, t;
    pair_t  res;
    a = din.left;
    b = din.right;
    x = floor_shift(longint'(wet_gain) * (a + b), 14);
    damped = clip32(damped + floor_shift(longint'(damp_coef) * (x - damped), 16));
    r = damped;
    for (int s = 0; s < NUM_STAGES; s++) begin
      t = lines[s][pointer];
      r = clip32(r - floor_shift(longint'(feedback) * t, 15));
      lines[s][(pointer + ofs[s]) % LINE_DEPTH] = clip(r, SMIN, SMAX);
      r = clip32(r + t);
      if (s == STAGE_LEFT_TAP)
        res.left = SAMPLE_BITS'(clip(floor_shift(longint'(dry_gain) * a, 14) + r - damped,
                                     SMIN, SMAX));
    end
    res.right = SAMPLE_BITS'(clip(floor_shift(longint'(dry_gain) * b, 14) + r - damped,
                                  SMIN, SMAX));
    pointer = (pointer + 1) % LINE_DEPTH;
    return res;
  endfunction

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_OFFSET_ONE:   ofs[0] = val[OFFSET_BITS-1:0];
      CFG_OFFSET_TWO:   ofs[1] = val[OFFSET_BITS-1:0];
      CFG_OFFSET_THREE: ofs[2] = val[OFFSET_BITS-1:0];
      CFG_OFFSET_FOUR:  ofs[3] = val[OFFSET_BITS-1:0];
      CFG_DAMP_COEF:    damp_coef = val;
      CFG_WET_GAIN:     wet_gain = val;
      CFG_DRY_GAIN:     dry_gain = val;
      CFG_FEEDBACK:     feedback = val;
      default: ;
    endcase
  endtask

  // Sends one word; valid stays high across back-to-back words of a burst.
  task automatic send_pair(pair_t din, bit hold);
    s_axis_tdata <= DATA_BITS'(din);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    expected_out.push_back(reverb_pair(din));
    @(negedge clk);
    if (!hold) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    while (expected_out.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample(int mode);
    case (mode)
      0: return SAMPLE_BITS'(SMAX);
      1: return SAMPLE_BITS'(SMIN);
      2: return $signed(SAMPLE_BITS'($urandom_range(0, 255)) - SAMPLE_BITS'(128));
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  always @(negedge clk) begin
    if (stall_rx)
      m_axis_tready <= 1'b0;
    else
      m_axis_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
  end

  always @(posedge clk) begin
    pair_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[2*SAMPLE_BITS-1:0];
      if (expected_out.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output word %h", got);
      end else begin
        want = expected_out.pop_front();
        if (m_axis_tdata !== DATA_BITS'(want)) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
                     want.left, want.right, got.left, got.right);
        end
      end
    end
  end

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    bit                            known;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } row_t;

  row_t dir_rows [10] = '{
    '{24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0},
    '{24'sh7FFFFF, 24'sh7FFFFF, 1'b0, 24'sd0, 24'sd0},
    '{24'sh800000, 24'sh800000, 1'b0, 24'sd0, 24'sd0},
    '{24'sh7FFFFF, 24'sh800000, 1'b0, 24'sd0, 24'sd0},
    '{24'sh800000, 24'sh7FFFFF, 1'b0, 24'sd0, 24'sd0},
    '{24'sd1, -24'sd1, 1'b0, 24'sd0, 24'sd0},
    '{24'sd123456, -24'sd654321, 1'b0, 24'sd0, 24'sd0},
    '{24'sh555555, 24'shAAAAAA, 1'b0, 24'sd0, 24'sd0},
    '{24'shAAAAAA, 24'sh555555, 1'b0, 24'sd0, 24'sd0},
    '{24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0}
  };

  initial begin
    int sent;
    int mode;
    int burst;
    pair_t p, want;
    reset_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    stall_rx = 1'b0;

    foreach (dir_rows[i]) begin
      p.left = dir_rows[i].left;
      p.right = dir_rows[i].right;
      send_pair(p, 1'b0);
      if (dir_rows[i].known) begin
        want.left = dir_rows[i].left_out;
        want.right = dir_rows[i].right_out;
        if (expected_out[$] !== want) begin
          errors++;
          if (errors <= 10) $display("model row %0d disagrees with table", i);
        end
      end
    end
    wait_idle();

    // Extreme settings: offsets of 0, 1023, 1024 (truncated to 0) and 1, full gains, feedback above nominal.
    write_reg(CFG_OFFSET_ONE, 16'd0);
    write_reg(CFG_OFFSET_TWO, 16'd1023);
    write_reg(CFG_OFFSET_THREE, 16'd1024);
    write_reg(CFG_OFFSET_FOUR, 16'd1);
    write_reg(CFG_DAMP_COEF, 16'hFFFF);
    write_reg(CFG_WET_GAIN, 16'hFFFF);
    write_reg(CFG_DRY_GAIN, 16'hFFFF);
    write_reg(CFG_FEEDBACK, 16'hFFFF);
    for (int i = 0; i < 12; i++) begin
      p.left = rand_sample(i % 4);
      p.right = rand_sample((i + 1) % 4);
      send_pair(p, 1'b0);
    end
    wait_idle();
    write_reg(CFG_DAMP_COEF, 16'd0);
    write_reg(CFG_WET_GAIN, 16'd0);
    write_reg(CFG_DRY_GAIN, 16'd0);
    write_reg(CFG_FEEDBACK, 16'd0);
    for (int i = 0; i < 4; i++) begin
      p.left = rand_sample(3);
      p.right = rand_sample(3);
      send_pair(p, 1'b0);
    end
    wait_idle();

    sent = 0;
    for (int phase = 0; phase < 5; phase++) begin
      for (int r = 0; r < 8; r++)
        write_reg(CFG_IDX_BITS'(r), phase == 4 ? 16'($urandom_range(0, 65535))
                  : (r < 4 ? 16'($urandom_range(0, 1023))
                  : (r == 7 ? 16'($urandom_range(0, 32768)) : 16'($urandom))));
      while (sent < (phase + 1) * RANDOM_WORDS / 5) begin
        burst = $urandom_range(1, 20);
        for (int k = 0; k < burst; k++) begin
          mode = $urandom_range(0, 9);
          p.left = rand_sample(mode < 1 ? 0 : (mode < 2 ? 1 : (mode < 4 ? 2 : 3)));
          mode = $urandom_range(0, 9);
          p.right = rand_sample(mode < 1 ? 0 : (mode < 2 ? 1 : (mode < 4 ? 2 : 3)));
          send_pair(p, k != burst - 1);
          sent++;
        end
        repeat ($urandom_range(0, 40)) @(negedge clk);
      end
      wait_idle();
    end

    if (errors == 0)
      $display("allpass_ambience_reverb_core_tb passed");
    else
      $display("allpass_ambience_reverb_core_tb failed");
    $finish;
  end

  initial begin
    #6000000;
    $display("allpass_ambience_reverb_core_tb failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/apr_pkg.sv
rtl/core/apr_line.sv
rtl/core/apr_ctrl.sv
rtl/core/apr_datapath.sv
rtl/core/allpass_ambience_reverb_core.sv
test/allpass_ambience_reverb_core_tb.sv
